// ===== rtl/integer_to_radix_ascii_core_macros.svh =====
// Assertion macros shared by the radix text converter RTL.
`ifndef INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ITR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ITR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITR_ASSERT_IMP(lbl, ante, cons, msg)
`define ITR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/itr_pkg.sv =====
// Types, constants and helpers of the radix text converter.
package itr_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned RADIX_IN_W    = 8;
  localparam int unsigned RADIX_W       = 5;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned STEP_BITS     = 8;

  localparam logic [RADIX_IN_W-1:0] RADIX_MIN = 8'd2;
  localparam logic [RADIX_IN_W-1:0] RADIX_MAX = 8'd16;
  localparam logic [RADIX_IN_W-1:0] RADIX_DEC = 8'd10;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_BAD  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_SIGN = 6'b001000,
    ST_RD   = 6'b010000,
    ST_PUT  = 6'b100000
  } itr_state_e;

  function automatic logic [CHAR_W-1:0] itr_glyph(input logic [DIGIT_W-1:0] digit);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, digit};
    if (digit < DIGIT_TEN) begin
      return CHAR_ZERO + ext;
    end
    return CHAR_LOW_A + ext - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
  endfunction

endpackage

// ===== rtl/itr_if.sv =====
// Valid/ready channel interfaces of the radix text converter.
interface itr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic [7:0]  radix;

  modport source (output valid, output value_bits, output radix, input ready);
  modport sink   (input valid, input value_bits, input radix, output ready);
endinterface

interface itr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic       bad_radix;

  modport source (output valid, output text_char, output last_char, output bad_radix,
                  input ready);
  modport sink   (input valid, input text_char, input last_char, input bad_radix,
                  output ready);
endinterface

// ===== rtl/integer_to_radix_ascii_core.sv =====
// Radix text converter top level: sequencer, output register and unit wiring.
//
//   channel  dir  payload                              transfer
//   in_i     in   value_bits[31:0], radix[7:0]         valid & ready
//   out_o    out  text_char[7:0], last_char, bad_radix valid & ready
//
// Each digit costs one run of the shared divider; each character then passes
// through the registered digit store read.
// in_i.ready is high only while the sequencer is idle.
// A stalled out_o holds the sequencer in its emitting state.
// Reset is asynchronous, active low; no clearing pass is needed.
`include "integer_to_radix_ascii_core_macros.svh"

module integer_to_radix_ascii_core import itr_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  itr_in_if.sink    in_i,
  itr_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(WORD_BITS);

  itr_state_e         state_q, state_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               neg_q, neg_d;
  logic [AddrW-1:0]   cnt_q, cnt_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               out_bad_q, out_bad_d;
  logic               out_load;

  logic                         in_fire;
  logic                         radix_ok;
  logic [VALUE_W+WORD_BITS-1:0] value_ext;
  logic [WORD_BITS-1:0]         word_in;
  logic                         neg_in;
  logic [WORD_BITS-1:0]         mag_in;
  logic                         slot_free;

  logic                 div_start;
  logic [WORD_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0]   div_divisor;
  logic                 div_busy;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]   div_rem;
  logic                 st_wr_en;
  logic                 st_rd_en;
  logic [DIGIT_W-1:0]   st_rd_data;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign radix_ok   = (in_i.radix >= RADIX_MIN) && (in_i.radix <= RADIX_MAX);
  assign value_ext  = {{WORD_BITS{1'b0}}, in_i.value_bits};
  assign word_in    = value_ext[WORD_BITS-1:0];
  assign neg_in     = (in_i.radix == RADIX_DEC) && word_in[WORD_BITS-1];
  assign mag_in     = neg_in ? (~word_in) + WORD_BITS'(1) : word_in;
  assign slot_free  = !out_valid_q || out_o.ready;

  assign div_start    = (in_fire && radix_ok) ||
                        ((state_q == ST_DIV) && div_done && (div_quot != '0));
  assign div_dividend = (state_q == ST_IDLE) ? mag_in : div_quot;
  assign div_divisor  = (state_q == ST_IDLE) ? in_i.radix[RADIX_W-1:0] : radix_q;
  assign st_wr_en     = (state_q == ST_DIV) && div_done;
  assign st_rd_en     = (state_q == ST_RD);

  itr_divider #(
    .WordBits (WORD_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  itr_digit_stack #(
    .Depth (WORD_BITS)
  ) u_digit_stack (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (cnt_q),
    .wr_data_i (div_rem),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (st_rd_data)
  );

  always_comb begin
    state_d    = state_q;
    radix_d    = radix_q;
    neg_d      = neg_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    out_load   = 1'b0;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    out_bad_d  = out_bad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          radix_d = in_i.radix[RADIX_W-1:0];
          neg_d   = neg_in;
          cnt_d   = '0;
          state_d = radix_ok ? ST_DIV : ST_BAD;
        end
      end
      ST_BAD: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char_d = CHAR_NUL;
          out_last_d = 1'b1;
          out_bad_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_quot != '0) begin
            cnt_d = cnt_q + AddrW'(1);
          end else begin
            idx_d   = cnt_q;
            state_d = neg_q ? ST_SIGN : ST_RD;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char_d = CHAR_MINUS;
          out_last_d = 1'b0;
          out_bad_d  = 1'b0;
          state_d    = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char_d = itr_glyph(st_rd_data);
          out_last_d = (idx_q == '0);
          out_bad_d  = 1'b0;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - AddrW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    neg_q      <= neg_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.text_char = out_char_q;
  assign out_o.last_char = out_last_q;
  assign out_o.bad_radix = out_bad_q;

  `ITR_ASSERT_IMP(a_bad_is_last, out_valid_q && out_bad_q, out_last_q && (out_char_q == CHAR_NUL), "error transfer not last or not NUL")
  `ITR_ASSERT_NXT(a_div_restart, (state_q == ST_DIV) && div_done && (div_quot != '0), div_busy, "divider not restarted on non-zero quotient")
  `ITR_ASSERT_IMP(a_busy_in_div, div_busy, state_q == ST_DIV, "divider busy outside divide state")

endmodule

// ===== rtl/itr_divider.sv =====
// Shared restoring divider: one digit per run, STEP_BITS quotient bits per cycle.
`include "integer_to_radix_ascii_core_macros.svh"

module itr_divider import itr_pkg::*; #(
  parameter int unsigned WordBits = WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] dividend_i,
  input  logic [RADIX_W-1:0]  divisor_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [WordBits-1:0] quot_o,
  output logic [DIGIT_W-1:0]  rem_o
);

  localparam int unsigned Chunks  = (WordBits + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PadBits = Chunks * STEP_BITS;
  localparam int unsigned LeftW   = $clog2(Chunks + 1);

  logic [PadBits-1:0] work_q, work_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] d_q;
  logic [LeftW-1:0]   left_q;
  logic               done_q;

  always_comb begin
    logic [RADIX_W-1:0] part;
    work_d = work_q;
    rem_d  = rem_q;
    for (int i = 0; i < STEP_BITS; i++) begin
      part   = {rem_d[RADIX_W-2:0], work_d[PadBits-1]};
      work_d = {work_d[PadBits-2:0], 1'b0};
      if (part >= d_q) begin
        part      = part - d_q;
        work_d[0] = 1'b1;
      end
      rem_d = part;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (left_q == LeftW'(1));
      if (start_i) begin
        left_q <= LeftW'(Chunks);
      end else if (left_q != '0) begin
        left_q <= left_q - LeftW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PadBits'(dividend_i);
      rem_q  <= '0;
      d_q    <= divisor_i;
    end else if (left_q != '0) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = (left_q != '0);
  assign done_o = done_q;
  assign quot_o = work_q[WordBits-1:0];
  assign rem_o  = rem_q[DIGIT_W-1:0];

  `ITR_ASSERT_IMP(a_rem_below_divisor, left_q != '0, rem_q < d_q, "partial remainder reached divisor")
  `ITR_ASSERT_NXT(a_done_single, done_q, !done_q, "done held for more than one cycle")
  `ITR_ASSERT_IMP(a_start_idle, start_i, !busy_o, "divider started while busy")

endmodule

// ===== rtl/itr_digit_stack.sv =====
// Digit store: written least significant first, read back in reverse.
module itr_digit_stack import itr_pkg::*; #(
  parameter int unsigned Depth = WORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [DIGIT_W-1:0]       wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [DIGIT_W-1:0]       rd_data_o
);

  logic [DIGIT_W-1:0] mem [Depth];
  logic [DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== tb/sv/integer_to_radix_ascii_core_tb.sv =====
// Self-checking testbench of the radix text converter with random flow control.
`timescale 1ns / 1ps

module integer_to_radix_ascii_core_tb;
  import itr_pkg::*;

  localparam string DIGIT_GLYPHS = "0123456789abcdef";
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam int unsigned PHASE_ITEMS = 70;
  localparam int unsigned MAX_REPORTS = 60;

  typedef struct packed {
    logic [VALUE_W-1:0]    value;
    logic [RADIX_IN_W-1:0] radix;
  } number_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text;
    logic              last;
    logic              bad;
  } glyph_t;

  logic clk_i;
  logic rst_ni;

  itr_in_if  in_ch ();
  itr_out_if out_ch ();

  integer_to_radix_ascii_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  number_t     numbers_to_send[$];
  glyph_t      due_glyphs[$];
  int unsigned mismatches;
  int unsigned idle_pct;
  int unsigned stall_pct;
  logic        hold_req;
  logic        rx_hold;

  always #10 clk_i = ~clk_i;

  // Expected text of one number, most significant character first.
  function automatic void spell_number(input logic [VALUE_W-1:0] value,
                                       input logic [RADIX_IN_W-1:0] radix);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] digit;
    logic [CHAR_W-1:0]  text[$];
    logic               neg;
    glyph_t             g;
    int                 i;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      g.text = CHAR_NUL;
      g.last = 1'b1;
      g.bad  = 1'b1;
      due_glyphs.push_back(g);
      return;
    end
    neg = (radix == RADIX_DEC) && value[VALUE_W-1];
    mag = neg ? (~value + VALUE_W'(1)) : value;
    do begin
      digit = mag % VALUE_W'(radix);
      text.push_front(DIGIT_GLYPHS[digit]);
      mag = mag / VALUE_W'(radix);
    end while (mag != '0);
    if (neg) begin
      text.push_front(CHAR_MINUS);
    end
    for (i = 0; i < text.size(); i++) begin
      g.text = text[i];
      g.last = (i == text.size() - 1);
      g.bad  = 1'b0;
      due_glyphs.push_back(g);
    end
  endfunction

  function automatic number_t pick_number();
    number_t n;
    case ($urandom_range(9))
      0:       n.radix = RADIX_IN_W'($urandom_range(255));
      1:       n.radix = RADIX_DEC;
      default: n.radix = RADIX_IN_W'($urandom_range(RADIX_MAX, RADIX_MIN));
    endcase
    case ($urandom_range(5))
      0: n.value = $urandom_range(300);
      1: begin
        case ($urandom_range(3))
          0: n.value = 32'h8000_0000;
          1: n.value = 32'h7fff_ffff;
          2: n.value = 32'hffff_ffff;
          default: n.value = '0;
        endcase
      end
      default: n.value = $urandom;
    endcase
    return n;
  endfunction

  function automatic number_t make_number(input logic [VALUE_W-1:0] value,
                                          input logic [RADIX_IN_W-1:0] radix);
    number_t n;
    n.value = value;
    n.radix = radix;
    return n;
  endfunction

  // Driver: hold an offered item until its transfer, then offer the next one.
  always @(posedge clk_i) begin : drive
    logic offered;
    offered = in_ch.valid;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        spell_number(in_ch.value_bits, in_ch.radix);
        void'(numbers_to_send.pop_front());
        offered = 1'b0;
      end
      if (!offered) begin
        if (numbers_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_ch.valid      <= 1'b1;
          in_ch.value_bits <= numbers_to_send[0].value;
          in_ch.radix      <= numbers_to_send[0].radix;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each character transfer with the oldest expectation.
  always @(posedge clk_i) begin : watch
    glyph_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (due_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result: expected none, actual text %h last %b bad %b",
                   $time, out_ch.text_char, out_ch.last_char, out_ch.bad_radix);
        end
      end else begin
        want = due_glyphs.pop_front();
        if (out_ch.text_char !== want.text) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: text_char mismatch: expected %h, actual %h",
                     $time, want.text, out_ch.text_char);
          end
        end
        if (out_ch.last_char !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: last_char mismatch: expected %b, actual %b",
                     $time, want.last, out_ch.last_char);
          end
        end
        if (out_ch.bad_radix !== want.bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: bad_radix mismatch: expected %b, actual %b",
                     $time, want.bad, out_ch.bad_radix);
          end
        end
      end
    end
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  // Hold off the receiver for a long stretch on request.
  initial begin : receiver_hold
    rx_hold = 1'b0;
    forever begin
      wait (hold_req);
      @(posedge clk_i);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold  <= 1'b0;
      hold_req <= 1'b0;
    end
  end

  task automatic drain();
    while (numbers_to_send.size() != 0 || due_glyphs.size() != 0 || hold_req) begin
      @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    int r;
    int p;
    int i;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value_bits = '0;
    in_ch.radix      = '0;
    out_ch.ready     = 1'b0;
    hold_req         = 1'b0;
    mismatches       = 0;
    idle_pct         = 0;
    stall_pct        = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = int'(RADIX_MIN); r <= int'(RADIX_MAX); r++) begin
      numbers_to_send.push_back(make_number(32'hffff_ffff, RADIX_IN_W'(r)));
    end
    numbers_to_send.push_back(make_number(32'h0000_0000, RADIX_DEC));
    numbers_to_send.push_back(make_number(32'h8000_0000, RADIX_DEC));
    numbers_to_send.push_back(make_number(32'h7fff_ffff, RADIX_DEC));
    numbers_to_send.push_back(make_number(32'h0000_0000, RADIX_MIN));
    numbers_to_send.push_back(make_number(32'h8000_0000, RADIX_MAX));
    numbers_to_send.push_back(make_number(32'h0000_0005, 8'd0));
    numbers_to_send.push_back(make_number(32'h0000_0005, 8'd1));
    numbers_to_send.push_back(make_number(32'hdead_beef, 8'd17));
    numbers_to_send.push_back(make_number(32'hffff_ffff, 8'd255));
    drain();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        numbers_to_send.push_back(pick_number());
      end
      drain();
    end

    // Stall the receiver while the sender keeps offering.
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    for (i = 0; i < 30; i++) begin
      numbers_to_send.push_back(pick_number());
    end
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_glyphs.size() == 0) begin
      $display("integer_to_radix_ascii_core_tb: PASS");
    end else begin
      $display("integer_to_radix_ascii_core_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("integer_to_radix_ascii_core_tb: FAIL");
    $finish;
  end

endmodule
